/* rtl/bml_pkg.sv */
// Shared constants for the banked MAC learning table: field widths and stream packing.
`default_nettype none

package bml_pkg;

  // Field widths of one input item.
  localparam int unsigned PortFieldW = 2;
  localparam int unsigned AddrFieldW = 48;

  // Field widths of one result item.
  localparam int unsigned EgressW = 2;

  // Bit positions of the input fields inside s_axis_tdata.
  localparam int unsigned PortLsb = 0;
  localparam int unsigned SrcLsb  = PortLsb + PortFieldW;
  localparam int unsigned DstLsb  = SrcLsb + AddrFieldW;
  localparam int unsigned InUsedW = DstLsb + AddrFieldW;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned InTdataW  = ((InUsedW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((EgressW + 7) / 8) * 8;

endpackage : bml_pkg

`default_nettype wire

/* rtl/bml_table_ram.sv */
// Simple dual-port table memory with one write port and one registered read port.
`default_nettype none

module bml_table_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 51
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  // A read and a write to the same address in one cycle return the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : bml_table_ram

`default_nettype wire

/* rtl/bml_clear_seq.sv */
// Post-reset sweep that writes every table entry to the invalid state.
`default_nettype none

module bml_clear_seq #(
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  output logic                   busy_o,
  output logic      [ADDR_W-1:0] addr_o
);

  logic              busy_q, busy_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      addr_d = addr_q + ADDR_W'(1);
      if (addr_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule : bml_clear_seq

`default_nettype wire

/* rtl/banked_mac_learning_table_unit.sv */
// Top level of the banked MAC learning and forwarding table.
//
//   Channel   Dir  Signals                      Contents
//   s_axis    in   tvalid, tready, tdata[103:0] ingress_port, source_address,
//                                                destination_address
//   m_axis    out  tvalid, tready, tdata[7:0],  egress_port in tdata,
//                  tuser[0]                     flood in tuser
//
// In the cycle of each input transfer the source entry is written and the destination
// entry is read, on the two ports of the table memory. The result passes through the
// lookup stage (registered read data) and then the output register before it is
// presented on m_axis, and a new transfer can be taken every cycle while the output
// side keeps taking results.
// After reset the block sweeps the whole table, one entry a cycle, to clear the valid
// bits of all 2^(BANK_SELECT_BITS + INDEX_BITS) entries (4096 at the defaults), with s_axis
// tready low throughout. A stall on m_axis holds the lookup stage, which then holds
// s_axis tready low.
`default_nettype none

module banked_mac_learning_table_unit
  import bml_pkg::*;
#(
  parameter int unsigned PORT_COUNT       = 4,
  parameter int unsigned ADDRESS_BITS     = 48,
  parameter int unsigned INDEX_BITS       = 10,
  parameter int unsigned BANK_SELECT_BITS = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // From bit 0: ingress_port[1:0], source_address[47:0], destination_address[47:0],
  // then zero fill.
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // From bit 0: egress_port[1:0], then zero fill.
  output logic      [OutTdataW-1:0] m_axis_tdata_o,
  // Bit 0: flood.
  output logic                      m_axis_tuser_o
);

  // Stored port width is the smallest width that holds PORT_COUNT ports.
  localparam int unsigned PortW   = $clog2(PORT_COUNT);
  // Tag keeps only the address bits that are in use.
  localparam int unsigned TagW    = (ADDRESS_BITS < AddrFieldW) ? ADDRESS_BITS : AddrFieldW;
  localparam int unsigned AddrW   = BANK_SELECT_BITS + INDEX_BITS;
  localparam int unsigned EntryW  = 1 + TagW + PortW;

  localparam logic [AddrFieldW-1:0] AddrMask =
      (ADDRESS_BITS >= AddrFieldW) ? {AddrFieldW{1'b1}}
                                   : ((AddrFieldW'(1) << ADDRESS_BITS) - AddrFieldW'(1));
  localparam logic [AddrW-1:0] BankMask = AddrW'((1 << BANK_SELECT_BITS) - 1);
  localparam logic [AddrW-1:0] SlotMask = AddrW'((1 << INDEX_BITS) - 1);

  // Unpacking of the input transfer.
  logic [PortFieldW-1:0] in_port;
  logic [AddrFieldW-1:0] src_mac, dst_mac;
  logic [PortW-1:0]      port_w;
  logic [AddrW-1:0]      src_loc, dst_loc;
  logic                  addr_same;

  assign in_port = s_axis_tdata_i[PortLsb +: PortFieldW];
  assign src_mac = s_axis_tdata_i[SrcLsb +: AddrFieldW] & AddrMask;
  assign dst_mac = s_axis_tdata_i[DstLsb +: AddrFieldW] & AddrMask;
  assign port_w  = PortW'(in_port);

  // Table location is the bank, taken from the low address bits, above the slot,
  // also taken from the low address bits. The two may share bits.
  assign src_loc = ((src_mac[AddrW-1:0] & BankMask) << INDEX_BITS)
                 | (src_mac[AddrW-1:0] & SlotMask);
  assign dst_loc = ((dst_mac[AddrW-1:0] & BankMask) << INDEX_BITS)
                 | (dst_mac[AddrW-1:0] & SlotMask);
  assign addr_same = (src_loc == dst_loc);

  // Clearing sweep after reset.
  logic             clr_busy;
  logic [AddrW-1:0] clr_addr;

  bml_clear_seq #(
    .ADDR_W (AddrW)
  ) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // Handshake and stage control.
  logic s_accept;
  logic out_load;
  logic s1_valid_q, s1_valid_d;
  logic m_valid_q, m_valid_d;

  assign out_load        = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy && (!s1_valid_q || out_load);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Table memory: the write port learns the source (or clears during the sweep),
  // the read port fetches the destination entry.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s_accept;
      ram_waddr = src_loc;
      ram_wdata = {1'b1, src_mac[TagW-1:0], port_w};
    end
  end

  bml_table_ram #(
    .ADDR_W (AddrW),
    .DATA_W (EntryW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_accept),
    .raddr_i (dst_loc),
    .rdata_o (ram_rdata)
  );

  // Lookup stage. When the destination shares its entry with the source learned in the
  // same transfer, the memory returns the old contents, so the fresh entry is forwarded.
  logic             s1_fwd_q;
  logic             s1_fwd_hit_q;
  logic [PortW-1:0] s1_fwd_port_q;
  logic [TagW-1:0]  s1_dst_tag_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_fwd_q      <= addr_same;
      s1_fwd_hit_q  <= (src_mac == dst_mac);
      s1_fwd_port_q <= port_w;
      s1_dst_tag_q  <= dst_mac[TagW-1:0];
    end
  end

  logic             rd_valid;
  logic [TagW-1:0]  rd_tag;
  logic [PortW-1:0] rd_port;
  logic             hit;
  logic [PortW-1:0] hit_port;

  assign {rd_valid, rd_tag, rd_port} = ram_rdata;

  always_comb begin
    if (s1_fwd_q) begin
      hit      = s1_fwd_hit_q;
      hit_port = s1_fwd_port_q;
    end else begin
      hit      = rd_valid && (rd_tag == s1_dst_tag_q);
      hit_port = rd_port;
    end
  end

  // Output register.
  logic [EgressW-1:0] egress_q;
  logic               flood_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      egress_q <= hit ? EgressW'(hit_port) : '0;
      flood_q  <= !hit;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end

    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(egress_q);
  assign m_axis_tuser_o  = flood_q;

endmodule : banked_mac_learning_table_unit

`default_nettype wire
